/* rtl/core/satr_pkg.sv */
// ----------------------------------------------------------------------------
// satr_pkg: shared constants for the shift-add twiddle rotator
// Default sizes, control word layout and stage shift step.
// ----------------------------------------------------------------------------
package satr_pkg;

  // default sizes
  localparam int DefDataWidth    = 16;
  localparam int DefNumStages    = 6;
  localparam int DefScaleTerms   = 4;
  localparam int DefFractionBits = 8;

  // control word layout
  localparam int WordBits   = 24;  // width of digit_word and scale_word
  localparam int DigitBits  = 4;   // one signed digit per micro-rotation
  localparam int StageShift = 3;   // stage n shifts by StageShift * n
  localparam int TermBits   = 6;   // one scale term: valid, negate, shift
  localparam int MaxTerms   = 4;   // terms summed in the adder tree
  localparam int TermValid  = 5;
  localparam int TermNeg    = 4;
  localparam int TermShBits = 4;

endpackage

/* rtl/core/shift_add_twiddle_rotator.sv */
// ----------------------------------------------------------------------------
// shift_add_twiddle_rotator: multiplierless complex rotator with scale stage
// Rotates a complex sample by NUM_STAGES (six by default) shift-and-digit micro-rotations, then
// scales each part by a sum of signed power-of-two terms.
// ----------------------------------------------------------------------------
// Pipeline: one input register, one register per micro-rotation, one register for the
//   scale terms, one output register after the adder tree and floor shift.
// Throughput: one beat per cycle; the whole pipe advances together and holds
//   only while the output register is full and not taken.
// Reset: rst_ni clears all valid bits at once; payload registers are not reset.
module shift_add_twiddle_rotator #(
  parameter int DATA_WIDTH    = satr_pkg::DefDataWidth,
  parameter int NUM_STAGES    = satr_pkg::DefNumStages,
  parameter int SCALE_TERMS   = satr_pkg::DefScaleTerms,
  parameter int FRACTION_BITS = satr_pkg::DefFractionBits,
  localparam int InW  = ((2 * DATA_WIDTH + 2 * satr_pkg::WordBits + 7) / 8) * 8,
  localparam int OutW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // from bit 0 up: real_in, imag_in, digit_word (24), scale_word (24), zero pad
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // from bit 0 up: real_out, imag_out, zero pad
  output logic [OutW-1:0] m_axis_tdata_o
);
  import satr_pkg::*;

  localparam int Dw    = DATA_WIDTH;
  localparam int Ext   = DATA_WIDTH + FRACTION_BITS;  // width of one scale term
  localparam int NumV  = NUM_STAGES + 3;              // valid bits along the pipe
  localparam int OutS  = NUM_STAGES + 2;              // index of the output stage

  // --------------------------------------------------------------------------
  // Flow control: one global advance. The pipe moves whenever the output
  // register is empty or being taken, so bubbles and beats both shift along.
  // --------------------------------------------------------------------------
  logic [NumV-1:0] vld_q;
  logic            adv;

  assign adv             = !vld_q[OutS] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[OutS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumV-2:0], s_axis_tvalid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Input register: unpack the beat.
  // --------------------------------------------------------------------------
  logic signed [Dw-1:0]       re_q  [NUM_STAGES+1];
  logic signed [Dw-1:0]       im_q  [NUM_STAGES+1];
  logic        [WordBits-1:0] dig_q [NUM_STAGES];
  logic        [WordBits-1:0] scl_q [NUM_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q[0]  <= s_axis_tdata_i[Dw-1:0];
      im_q[0]  <= s_axis_tdata_i[2*Dw-1:Dw];
      dig_q[0] <= s_axis_tdata_i[2*Dw +: WordBits];
      scl_q[0] <= s_axis_tdata_i[2*Dw+WordBits +: WordBits];
    end
  end

  // --------------------------------------------------------------------------
  // Micro-rotation stages. Stage n floor-shifts both parts by 3n, multiplies
  // by its 4-bit signed digit and cross-adds, all wrapped to the data width.
  // Stage 0 takes the nibble at 4*(NUM_STAGES-1), the top one by default; a nibble above the word reads as zero.
  // --------------------------------------------------------------------------
  for (genvar n = 0; n < NUM_STAGES; n++) begin : g_rot
    localparam int Shift = StageShift * n;
    localparam int Pos   = DigitBits * (NUM_STAGES - 1 - n);

    logic signed [DigitBits-1:0]    dig;
    logic signed [Dw-1:0]           sh_re, sh_im;
    logic signed [Dw+DigitBits-1:0] prod_re, prod_im;
    logic signed [Dw-1:0]           re_d, im_d;

    if (Pos + DigitBits <= WordBits) begin : g_dig
      assign dig = dig_q[n][Pos +: DigitBits];
    end else begin : g_nodig
      assign dig = '0;
    end

    // arithmetic shift fills with the sign, also for shifts past the width
    assign sh_re   = re_q[n] >>> Shift;
    assign sh_im   = im_q[n] >>> Shift;
    assign prod_re = sh_re * dig;
    assign prod_im = sh_im * dig;
    assign re_d    = re_q[n] - prod_im[Dw-1:0];
    assign im_d    = im_q[n] + prod_re[Dw-1:0];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        re_q[n+1]  <= re_d;
        im_q[n+1]  <= im_d;
        scl_q[n+1] <= scl_q[n];
      end
    end

    // digits only travel as far as the last stage that needs them
    if (n < NUM_STAGES - 1) begin : g_dig_fwd
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dig_q[n+1] <= dig_q[n];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale terms: each valid term is the part sign-extended, shifted left and
  // optionally negated, wrapped to Ext bits. Invalid or absent terms are zero.
  // --------------------------------------------------------------------------
  logic signed [Ext-1:0] ext_re, ext_im;
  logic signed [Ext-1:0] trm_re_q [MaxTerms];
  logic signed [Ext-1:0] trm_im_q [MaxTerms];

  assign ext_re = Ext'(re_q[NUM_STAGES]);
  assign ext_im = Ext'(im_q[NUM_STAGES]);

  for (genvar k = 0; k < MaxTerms; k++) begin : g_term
    logic signed [Ext-1:0] trm_re_d, trm_im_d;

    if (k < SCALE_TERMS) begin : g_used
      logic [TermBits-1:0]   cmd;
      logic signed [Ext-1:0] shl_re, shl_im;

      assign cmd    = scl_q[NUM_STAGES][TermBits*k +: TermBits];
      assign shl_re = ext_re <<< cmd[TermShBits-1:0];
      assign shl_im = ext_im <<< cmd[TermShBits-1:0];

      always_comb begin
        trm_re_d = '0;
        trm_im_d = '0;
        if (cmd[TermValid]) begin
          trm_re_d = cmd[TermNeg] ? -shl_re : shl_re;
          trm_im_d = cmd[TermNeg] ? -shl_im : shl_im;
        end
      end
    end else begin : g_unused
      assign trm_re_d = '0;
      assign trm_im_d = '0;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        trm_re_q[k] <= trm_re_d;
        trm_im_q[k] <= trm_im_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Adder tree and floor shift: pair sums wrap to Ext+1, the total to Ext+2,
  // then drop the fraction bits with an arithmetic shift and wrap to Dw.
  // --------------------------------------------------------------------------
  logic signed [Ext:0]   p01_re, p23_re, p01_im, p23_im;
  logic signed [Ext+1:0] sum_re, sum_im, fl_re, fl_im;
  logic signed [Dw-1:0]  out_re_q, out_im_q;

  assign p01_re = (Ext+1)'(trm_re_q[0]) + (Ext+1)'(trm_re_q[1]);
  assign p23_re = (Ext+1)'(trm_re_q[2]) + (Ext+1)'(trm_re_q[3]);
  assign p01_im = (Ext+1)'(trm_im_q[0]) + (Ext+1)'(trm_im_q[1]);
  assign p23_im = (Ext+1)'(trm_im_q[2]) + (Ext+1)'(trm_im_q[3]);
  assign sum_re = (Ext+2)'(p01_re) + (Ext+2)'(p23_re);
  assign sum_im = (Ext+2)'(p01_im) + (Ext+2)'(p23_im);
  assign fl_re  = sum_re >>> FRACTION_BITS;
  assign fl_im  = sum_im >>> FRACTION_BITS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_re_q <= fl_re[Dw-1:0];
      out_im_q <= fl_im[Dw-1:0];
    end
  end

  assign m_axis_tdata_o = OutW'({out_im_q, out_re_q});

endmodule
